// File: sv/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants
// Command and status records between controller and datapath, generator
// constants.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD  = 48'h0000_0000_000B;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_BOUND = 2'd1;
    localparam logic [1:0] MODE_INT64 = 2'd2;
    localparam logic [1:0] MODE_FRAC  = 2'd3;

    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_LATCH    = 3'd1;
    localparam logic [2:0] OP_MUL      = 3'd2;
    localparam logic [2:0] OP_EVAL     = 3'd3;
    localparam logic [2:0] OP_DIV_STEP = 3'd4;
    localparam logic [2:0] OP_CHECK    = 3'd5;
    localparam logic [2:0] OP_OUT      = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       second;
        logic       pow2;
        logic       redraw;
    } status_t;

endpackage

// File: sv/lcg_datapath.sv
// ----------------------------------------------------------------------------
// lcg_datapath: generator state, multiplier, divider and result registers
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module lcg_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  lcg_pkg::cmd_t    cmd,
    output lcg_pkg::status_t status,
    input  logic             cfg_wen,
    input  logic [47:0]      cfg_wdata,
    input  logic [1:0]       mode,
    input  logic [5:0]       bit_count,
    input  logic [30:0]      bound,
    output logic [63:0]      value
);
    import lcg_pkg::*;

    logic [47:0] state_reg;
    logic [47:0] acc_reg;
    logic [1:0]  mode_reg;
    logic [5:0]  k_reg;
    logic [30:0] n_reg;
    logic        second_reg;
    logic [31:0] bits_reg;
    logic [31:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] value_reg;

    logic [15:0] chunk;
    logic [50:0] prod;
    logic [5:0]  k_eff;
    logic [5:0]  shamt;
    logic [47:0] shifted;
    logic [31:0] draw_k;
    logic [31:0] draw31;
    logic [31:0] draw32;
    logic [61:0] bmul;
    logic [31:0] rem_sh;
    logic [31:0] redraw_sum;

    always_comb
    begin
        case (cmd.cnt[1:0])
            2'd0:    chunk = state_reg[15:0];
            2'd1:    chunk = state_reg[31:16];
            default: chunk = state_reg[47:32];
        endcase
        prod = {35'd0, chunk} * {16'd0, LCG_MULT[34:0]};
    end

    // draw of k top bits
    always_comb
    begin
        k_eff   = (k_reg > 6'd32) ? 6'd32 : k_reg;
        shamt   = 6'd48 - k_eff;
        shifted = state_reg >> shamt;
        draw_k  = (k_reg == 6'd0) ? 32'd0 : shifted[31:0];
        draw31  = {1'b0, state_reg[47:17]};
        draw32  = state_reg[47:16];
        bmul    = {31'd0, n_reg} * {31'd0, draw31[30:0]};
        rem_sh  = {rem_reg[30:0], bits_reg[cmd.cnt]};
        redraw_sum = bits_reg - rem_reg + {1'b0, n_reg} - 32'd1;
    end

    assign status.mode   = mode_reg;
    assign status.second = second_reg;
    assign status.pow2   = ((n_reg & (~n_reg + 31'd1)) == n_reg);
    assign status.redraw = redraw_sum[31];
    assign value         = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LCG_MULT;
            second_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                state_reg <= cfg_wdata ^ LCG_MULT;
            else if (cmd.op == OP_MUL && cmd.cnt[1:0] == 2'd2)
                state_reg <= acc_reg + {prod[15:0], 32'd0} + LCG_ADD;
            if (cmd.op == OP_LATCH)
                second_reg <= 1'b0;
            else if (cmd.op == OP_EVAL)
                second_reg <= ~second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                mode_reg <= mode;
                k_reg    <= bit_count;
                n_reg    <= bound;
            end
            OP_MUL:
            begin
                if (cmd.cnt[1:0] == 2'd0)
                    acc_reg <= prod[47:0];
                else if (cmd.cnt[1:0] == 2'd1)
                    acc_reg <= acc_reg + {prod[31:0], 16'd0};
            end
            OP_EVAL:
            begin
                case (mode_reg)
                    MODE_RAW:   res_reg <= {32'd0, draw_k};
                    MODE_BOUND:
                    begin
                        res_reg  <= {33'd0, bmul[61:31]};
                        bits_reg <= draw31;
                        rem_reg  <= 32'd0;
                    end
                    MODE_INT64:
                    begin
                        if (!second_reg)
                            res_reg <= {draw32, 32'd0};
                        else
                            res_reg <= res_reg + {{32{draw32[31]}}, draw32};
                    end
                    default:
                    begin
                        if (!second_reg)
                            res_reg <= {37'd0, state_reg[47:22], 1'b0} << 26;
                        else
                            res_reg <= res_reg + {37'd0, state_reg[47:21]};
                    end
                endcase
            end
            OP_DIV_STEP:
            begin
                if (rem_sh >= {1'b0, n_reg})
                    rem_reg <= rem_sh - {1'b0, n_reg};
                else
                    rem_reg <= rem_sh;
            end
            OP_CHECK:   res_reg   <= {32'd0, rem_reg};
            OP_OUT:     value_reg <= res_reg;
            default:    ;
        endcase
    end

endmodule

// File: sv/lcg_controller.sv
// ----------------------------------------------------------------------------
// lcg_controller: request sequencer
// Steps the generator, runs the divider and hands results to the output.
// ----------------------------------------------------------------------------
module lcg_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output lcg_pkg::cmd_t    cmd,
    input  lcg_pkg::status_t status
);
    import lcg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;
    logic       load_out;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign load_out  = (state_reg == S_OUT) && (!ovalid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.op      = OP_NONE;
        cmd.cnt     = cnt_reg;
        ovalid_next = ovalid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    cnt_next   = 5'd0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.op   = OP_EVAL;
                cnt_next = 5'd0;
                case (status.mode)
                    MODE_RAW:   state_next = S_OUT;
                    MODE_BOUND:
                    begin
                        cnt_next   = 5'd30;
                        state_next = status.pow2 ? S_OUT : S_DIV;
                    end
                    default:    state_next = status.second ? S_OUT : S_STEP;
                endcase
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = OP_CHECK;
                cnt_next   = 5'd0;
                state_next = status.redraw ? S_STEP : S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    cmd.op      = OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= 5'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// File: sv/lcg48_random_generator_unit.sv
// ----------------------------------------------------------------------------
// lcg48_random_generator_unit: 48-bit linear congruential generator
// Serves raw-bit, bounded, 64-bit and fraction-numerator requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request (mode, bit_count, bound) is taken when in_valid is high and
//   in_stall is low; each request gives one result on value, taken when
//   out_valid is high and out_stall is low.
//   Each draw steps the state through a partial-product multiplier that
//   adds the products of the low, middle and high 16-bit state chunks.
//   After the draw, raw bits and power-of-two bounds go to the output,
//   int64 and fraction take a second draw first, and other bounds run the
//   bit-serial divider and a range test, which may ask for a redraw.
//   One request is in flight at a time; the next one can be accepted in
//   the cycle after a result is loaded. A new request is taken while the
//   previous result still waits in the output register.
//   If the receiver stalls, hold the result; the next one waits in the
//   controller until the output register frees up.
//   Reset loads the state with the scrambled zero seed and empties the
//   output. Write cfg_wdata with cfg_wen only while idle: it reloads the
//   state with the scrambled seed.
// ----------------------------------------------------------------------------
module lcg48_random_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [5:0]  bit_count,
    input  logic [30:0] bound,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    input  logic        cfg_wen,
    input  logic [47:0] cfg_wdata
);
    import lcg_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: owns the handshakes and the draw loop
    lcg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // state, multiplier, divider, result and output registers
    lcg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .mode      (mode),
        .bit_count (bit_count),
        .bound     (bound),
        .value     (value)
    );

endmodule

// File: dv/tb_lcg48_random_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg48_random_generator_unit: self-checking bench for the LCG48 generator
// Drives random and directed requests under several idle/stall phases,
// reloads the seed between phases, predicts each value with a local model
// of the generator and compares results in order.
// ----------------------------------------------------------------------------
module tb_lcg48_random_generator_unit;
    import lcg_pkg::*;

    localparam logic [47:0] STATE_MASK = 48'hFFFF_FFFF_FFFF;
    localparam int          CYCLE_LIMIT = 3000000;

    // Predicts generator values and keeps the queue of pending ones.
    class value_scoreboard;
        logic [47:0] lcg_state;
        logic [63:0] pending_values[$];
        int          fail_count;

        function new();
            lcg_state  = LCG_MULT;
            fail_count = 0;
        endfunction

        function void reseed(logic [47:0] seed_val);
            lcg_state = (seed_val ^ LCG_MULT) & STATE_MASK;
        endfunction

        function logic [31:0] take_bits(int k);
            logic [95:0] prod;
            prod      = lcg_state * LCG_MULT + LCG_ADD;
            lcg_state = prod[47:0];
            if (k == 0)
                return 32'd0;
            if (k > 32)
                k = 32;
            return 32'(lcg_state >> (48 - k));
        endfunction

        function logic [63:0] bounded_value(logic [31:0] n);
            logic [31:0] draw_bits;
            logic [31:0] rem;
            logic [63:0] prod;
            if ((n & (32'd0 - n)) == n)
            begin
                prod = 64'(n) * 64'(take_bits(31));
                return prod >> 31;
            end
            do
            begin
                draw_bits = take_bits(31);
                rem       = draw_bits % n;
            end while (((draw_bits - rem + (n - 32'd1)) & 32'h8000_0000) != 0);
            return 64'(rem);
        endfunction

        // Note an accepted request: compute and queue its value.
        function void note_request(logic [1:0] md, logic [5:0] k, logic [30:0] n);
            logic [63:0] hi;
            logic [63:0] lo;
            logic [63:0] v;
            case (md)
                MODE_RAW:   v = 64'(take_bits(int'(k)));
                MODE_BOUND: v = bounded_value({1'b0, n});
                MODE_INT64:
                begin
                    hi = 64'(take_bits(32));
                    lo = {{32{1'b0}}, take_bits(32)};
                    if (lo[31])
                        lo[63:32] = '1;
                    v = (hi << 32) + lo;
                end
                default:
                begin
                    hi = 64'(take_bits(26));
                    lo = 64'(take_bits(27));
                    v  = (hi << 27) + lo;
                end
            endcase
            pending_values.push_back(v);
        endfunction

        function void check_value(logic [63:0] actual);
            logic [63:0] exp_v;
            if (pending_values.size() == 0)
            begin
                $error("value: unexpected result %h", actual);
                fail_count++;
                return;
            end
            exp_v = pending_values.pop_front();
            if (exp_v !== actual)
            begin
                $error("value: expected %h actual %h", exp_v, actual);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [5:0]  bit_count;
    logic [30:0] bound;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic        cfg_wen;
    logic [47:0] cfg_wdata;

    value_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              cycle_count;

    lcg48_random_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .bit_count (bit_count),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: stall at random per phase; check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_value(value);
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one request; hold it until accepted, then note it.
    // Valid stays high after acceptance; drop it while idling.
    task automatic send_request(logic [1:0] md, logic [5:0] k, logic [30:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= md;
        bit_count <= k;
        bound     <= n;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(md, k, n);
    endtask

    // Drop valid and wait until every queued value has arrived.
    task automatic wait_empty;
        in_valid <= 1'b0;
        while (sb.pending_values.size() != 0)
            @(posedge clk);
    endtask

    // Wait until every queued value has arrived, plus a settle margin.
    task automatic drain;
        wait_empty();
        repeat (20)
            @(posedge clk);
    endtask

    // Idle-only seed write; the model reseeds at the same edge.
    task automatic write_seed(logic [47:0] s);
        cfg_wen   <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        sb.reseed(s);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_request;
        logic [30:0] n;
        int          pick;
        pick = $urandom_range(9);
        case (pick)
            0:       n = 31'(1) << $urandom_range(30);
            1:       n = 31'($urandom_range(16, 1));
            2:       n = 31'h7FFF_FFFF - 31'($urandom_range(3));
            3:       n = 31'($urandom_range(31'h7FFF_FFFF, 31'h4000_0000));
            default: n = 31'($urandom);
        endcase
        if ($urandom_range(19) == 0)
            n = 31'd0;
        send_request(2'($urandom_range(3)), 6'($urandom), n);
    endtask

    initial
    begin
        logic [47:0] seeds[5];
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_RAW;
        bit_count      = 6'd0;
        bound          = 31'd0;
        out_stall      = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = 48'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset seed first, field extremes, every mode.
        send_request(MODE_RAW, 6'd0, 31'd0);
        send_request(MODE_RAW, 6'd1, 31'd0);
        send_request(MODE_RAW, 6'd32, 31'd0);
        send_request(MODE_RAW, 6'd33, 31'h7FFF_FFFF);
        send_request(MODE_RAW, 6'd63, 31'h7FFF_FFFF);
        send_request(MODE_BOUND, 6'd0, 31'd0);
        send_request(MODE_BOUND, 6'd0, 31'd1);
        send_request(MODE_BOUND, 6'd0, 31'd2);
        send_request(MODE_BOUND, 6'd0, 31'h4000_0000);
        send_request(MODE_BOUND, 6'd0, 31'd3);
        send_request(MODE_BOUND, 6'd0, 31'h7FFF_FFFF);
        send_request(MODE_BOUND, 6'd0, 31'h4000_0001);
        send_request(MODE_BOUND, 6'd0, 31'h6000_0000);
        send_request(MODE_INT64, 6'd63, 31'h7FFF_FFFF);
        send_request(MODE_FRAC, 6'd0, 31'd0);
        drain();

        // Seed extremes and random seeds, one phase each.
        seeds[0] = 48'd0;
        seeds[1] = STATE_MASK;
        seeds[2] = LCG_MULT;
        seeds[3] = {16'($urandom), 32'($urandom)};
        seeds[4] = {16'($urandom), 32'($urandom)};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_seed(seeds[ph]);
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 31;
                end
            endcase
            for (int i = 0; i < 340; i++)
            begin
                random_request();
                // Halfway through each phase, hold off until the block has caught up.
                if (i == 170)
                    wait_empty();
            end
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
